// ===== design/mamf_pkg.sv =====
// ---------------------------------------------------------------------------
// mamf_pkg
// Shared widths and the command/status bundles that pass between the mode
// finder controller and its datapath.
// ---------------------------------------------------------------------------
package mamf_pkg;

    localparam int VALUE_W    = 32;
    localparam int MULT_W     = 5;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 40;
    localparam int OUT_PAD_W  = OUT_DATA_W - VALUE_W - MULT_W;

    // Controller to datapath
    typedef struct packed {
        logic load;     // input transfer: store the sample
        logic start;    // input transfer closes the set: clear the running best
        logic issue;    // issue the next (i, j) compare pair
        logic publish;  // copy the best pair into the output register
    } mamf_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic issue_last;  // current pair is the final one of the set
    } mamf_status_t;

endpackage

// ===== design/mode_and_multiplicity_finder_unit.sv =====
// ---------------------------------------------------------------------------
// mode_and_multiplicity_finder_unit
// Finds the most frequent value of a loaded set and how often it occurs.
// ---------------------------------------------------------------------------
// Usage:
//   Samples arrive on the s_ stream, one 32-bit signed value per transfer;
//   the transfer with s_tlast high closes the set. Up to MAX_ITEMS values are
//   kept, later ones in the same set are dropped (tlast still closes it).
//   One result per set leaves on the m_ stream: mode value and multiplicity,
//   the earliest loaded value winning on ties.
//   Samples are taken back to back while loading. After the closing transfer
//   the block sweeps every (i, j) pair of stored values, one compare per cycle
//   through a dual-read store, then drains the read stage and, once the output
//   register is free, registers the result there and raises m_tvalid with it.
//   s_tready is low from the closing transfer until the result is registered,
//   so no sample of the next set is taken while a set is swept.
//   The output register holds the result while the receiver stalls; loading
//   of the next set proceeds meanwhile, and only the hand-off of the next
//   result waits for the transfer. Reset empties the set, drops any pending
//   result and needs no clearing pass.
// ---------------------------------------------------------------------------
module mode_and_multiplicity_finder_unit
    import mamf_pkg::*;
#(
    parameter int MAX_ITEMS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [31:0] sample_value
    input  logic                  s_tlast,   // last_sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [31:0] mode_value, [36:32] multiplicity
);

    mamf_cmd_t    cmd;
    mamf_status_t st;

    mamf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    mamf_dp #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .st      (st),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ===== design/mamf_dp.sv =====
// ---------------------------------------------------------------------------
// mamf_dp
// Sample store, compare-pair address counters, registered read stage,
// occurrence counter, running best and the output register.
// ---------------------------------------------------------------------------
module mamf_dp
    import mamf_pkg::*;
#(
    parameter int MAX_ITEMS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mamf_cmd_t             cmd,
    output mamf_status_t          st,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [VALUE_W-1:0] store_mem [MAX_ITEMS];

    logic [CW-1:0]      fill_reg, fill_next;
    logic [AW-1:0]      i_reg, i_next;
    logic [AW-1:0]      j_reg, j_next;
    logic               v1_reg, end1_reg;
    logic [VALUE_W-1:0] di_reg, dj_reg;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      best_count_reg, best_count_next;
    logic [VALUE_W-1:0] best_value_reg, best_value_next;
    logic [VALUE_W-1:0] out_value_reg;
    logic [MULT_W-1:0]  out_count_reg;

    logic [AW-1:0]      last_idx;
    logic               not_full;
    logic               j_wrap;
    logic               eq;
    logic [CW-1:0]      cnt_sum;

    assign last_idx = AW'(fill_reg - CW'(1));
    assign not_full = (fill_reg < CW'(MAX_ITEMS));
    assign j_wrap   = (j_reg == last_idx);
    assign eq       = (di_reg == dj_reg);
    assign cnt_sum  = cnt_reg + CW'(eq);

    assign st.issue_last = (i_reg == last_idx) && j_wrap;

    // Store write port and the two registered read ports
    always_ff @(posedge clk)
    begin
        if (cmd.load && not_full)
        begin
            store_mem[fill_reg[AW-1:0]] <= s_tdata;
        end
        di_reg <= store_mem[i_reg];
        dj_reg <= store_mem[j_reg];
    end

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.publish)
        begin
            fill_next = '0;
        end
        else if (cmd.load && not_full)
        begin
            fill_next = fill_reg + CW'(1);
        end

        i_next = '0;
        j_next = '0;
        if (cmd.issue)
        begin
            if (j_wrap)
            begin
                i_next = i_reg + AW'(1);
            end
            else
            begin
                i_next = i_reg;
                j_next = j_reg + AW'(1);
            end
        end

        cnt_next        = cnt_reg;
        best_count_next = best_count_reg;
        best_value_next = best_value_reg;
        if (v1_reg)
        begin
            cnt_next = end1_reg ? '0 : cnt_sum;
            // strict compare keeps the earliest value on ties
            if (end1_reg && (cnt_sum > best_count_reg))
            begin
                best_count_next = cnt_sum;
                best_value_next = di_reg;
            end
        end
        if (cmd.start)
        begin
            best_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg       <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            v1_reg         <= 1'b0;
            end1_reg       <= 1'b0;
            cnt_reg        <= '0;
            best_count_reg <= '0;
        end
        else
        begin
            fill_reg       <= fill_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            v1_reg         <= cmd.issue;
            end1_reg       <= cmd.issue && j_wrap;
            cnt_reg        <= cnt_next;
            best_count_reg <= best_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_value_reg <= best_value_next;
        if (cmd.publish)
        begin
            out_value_reg <= best_value_reg;
            out_count_reg <= MULT_W'(best_count_reg);
        end
    end

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_count_reg, out_value_reg};

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(MAX_ITEMS))
        else $error("fill count past store depth");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= fill_reg)
        else $error("occurrence count exceeds set size");

    a_issue_filled: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (fill_reg != '0))
        else $error("compare issued on an empty set");

endmodule

// ===== design/mamf_ctrl.sv =====
// ---------------------------------------------------------------------------
// mamf_ctrl
// Sequencer: load the set, sweep all compare pairs, drain the read stage,
// then hand the result to the output register.
// ---------------------------------------------------------------------------
module mamf_ctrl
    import mamf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tlast,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output mamf_cmd_t    cmd,
    input  mamf_status_t st
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_PUBLISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                s_tready  = 1'b1;
                cmd.load  = s_tvalid;
                cmd.start = s_tvalid && s_tlast;
                if (s_tvalid && s_tlast)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (st.issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last compare pair is in the read stage
                state_next = ST_PUBLISH;
            end
            ST_PUBLISH:
            begin
                cmd.publish = out_free;
                if (out_free)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        m_tvalid_next = m_tvalid_reg;
        if (cmd.publish)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    a_no_load_while_scan: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.issue)
        else $error("input accepted during pair sweep");

    a_publish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!m_tvalid_reg || m_tready))
        else $error("result overwritten before transfer");

    a_sweep_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && st.issue_last) |=> (state_reg == ST_DRAIN && !cmd.issue))
        else $error("sweep did not stop after last pair");

endmodule

// ===== sim/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// Drives sample sets into mode_and_multiplicity_finder_unit, predicts the
// mode and multiplicity of every closed set, and checks each result transfer
// in order under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
module testbench;
    import mamf_pkg::*;

    localparam int SET_DEPTH    = 16;
    localparam int CLK_HIGH     = 6;
    localparam int CLK_LOW      = 6;
    localparam int RESET_CYCLES = 11;
    // a full set sweeps SET_DEPTH^2 compare pairs before m_tvalid rises
    localparam int DRAIN_CYCLES = SET_DEPTH * SET_DEPTH + 40;
    localparam int HOLD_CYCLES  = 600;
    localparam int RUN_LIMIT    = 400000 * (CLK_HIGH + CLK_LOW);

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [MULT_W-1:0]  count;
    } mode_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;    // [31:0] sample_value
    logic                  s_tlast = 1'b0;  // last_sample
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;         // [31:0] mode_value, [36:32] multiplicity

    // predictor state: values of the set being loaded, results still owed
    logic [VALUE_W-1:0] loaded_set[$];
    mode_result_t       expected_modes[$];

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    int  samples_sent   = 0;
    int  error_count    = 0;
    logic hold_active   = 1'b0;
    event hold_go;

    mode_and_multiplicity_finder_unit #(.MAX_ITEMS(SET_DEPTH)) uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #CLK_LOW clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    initial
    begin
        #RUN_LIMIT;
        $display("** mode_and_multiplicity_finder_unit: FAILED **");
        $finish;
    end

    // ---------------- predictor ----------------
    function automatic void predict_sample(logic [VALUE_W-1:0] v, logic last);
        mode_result_t r;
        int           hits;
        int           top;
        if (loaded_set.size() < SET_DEPTH)
            loaded_set.push_back(v);
        if (last)
        begin
            top = 0;
            r.value = '0;
            foreach (loaded_set[i])
            begin
                hits = 0;
                foreach (loaded_set[j])
                    if (loaded_set[j] == loaded_set[i])
                        hits++;
                // strict compare keeps the earliest value on a tie
                if (hits > top)
                begin
                    top = hits;
                    r.value = loaded_set[i];
                end
            end
            r.count = top[MULT_W-1:0];
            expected_modes.push_back(r);
            loaded_set.delete();
        end
    endfunction

    // ---------------- receiver side ----------------
    always @(posedge clk)
    begin
        if (hold_active)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active <= 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_results
        mode_result_t want;
        if (m_tvalid && m_tready)
        begin
            if (expected_modes.size() == 0)
            begin
                $display("%0t: unexpected result transfer, expected none, got %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                want = expected_modes.pop_front();
                if (m_tdata[VALUE_W-1:0] !== want.value)
                begin
                    $display("%0t: mode_value mismatch, expected %h, got %h",
                             $time, want.value, m_tdata[VALUE_W-1:0]);
                    error_count++;
                end
                if (m_tdata[VALUE_W +: MULT_W] !== want.count)
                begin
                    $display("%0t: multiplicity mismatch, expected %0d, got %0d",
                             $time, want.count, m_tdata[VALUE_W +: MULT_W]);
                    error_count++;
                end
                if (m_tdata[OUT_DATA_W-1:VALUE_W+MULT_W] !== '0)
                begin
                    $display("%0t: tdata padding mismatch, expected 0, got %h",
                             $time, m_tdata[OUT_DATA_W-1:VALUE_W+MULT_W]);
                    error_count++;
                end
            end
        end
    end

    // ---------------- sender side ----------------
    // Called right after a rising edge; returns right after the transfer edge.
    task automatic send_sample(input logic [VALUE_W-1:0] v, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;   // junk while idle
            s_tlast  <= 1'($urandom_range(1));
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_sample(v, last);
        samples_sent++;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom;
            1: return VALUE_W'($urandom_range(6)) - VALUE_W'(3);
            2:
            begin
                case ($urandom_range(3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            default: return VALUE_W'($urandom_range(15)) << $urandom_range(28);
        endcase
    endfunction

    // Mostly short sets drawn from a small pool so repeats and ties are common;
    // a few run past the store depth.
    task automatic send_random_set();
        logic [VALUE_W-1:0] pool[4];
        logic [VALUE_W-1:0] v;
        int                 n;
        int                 npool;
        int                 pick;
        pick = $urandom_range(99);
        if (pick < 70)
            n = $urandom_range(1, 6);
        else if (pick < 92)
            n = $urandom_range(7, 15);
        else
            n = $urandom_range(16, 20);
        npool = $urandom_range(1, 4);
        for (int k = 0; k < npool; k++)
            pool[k] = pick_value();
        for (int k = 0; k < n; k++)
        begin
            v = ($urandom_range(9) == 0) ? pick_value() : pool[$urandom_range(npool - 1)];
            send_sample(v, k == n - 1);
        end
    endtask

    task automatic run_random_sets(input int quota);
        int first;
        first = samples_sent;
        while (samples_sent - first < quota)
            send_random_set();
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_modes.size() != 0)
            @(posedge clk);
    endtask

    // ---------------- tests ----------------
    task automatic test_directed_cases();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // single value closes a set of one
        send_sample(32'h5A5A_A5A5, 1'b1);
        // tie: earliest of the two wins
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1);
        // signed extremes, all 32 bits compared
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        // full store: the closing value is dropped, or it would break the tie
        for (int k = 0; k < SET_DEPTH / 2; k++)
            send_sample(32'h1234_5678, 1'b0);
        for (int k = 0; k < SET_DEPTH / 2; k++)
            send_sample(32'hEDCB_A987, 1'b0);
        send_sample(32'hEDCB_A987, 1'b1);
    endtask

    task automatic test_streaming();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random_sets(300);
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 69;
        recv_stall_pct = 0;
        run_random_sets(300);
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 69;
        run_random_sets(300);
    endtask

    task automatic test_mixed_idling();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_random_sets(280);
    endtask

    // results back up behind the held receiver until loading stalls
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> hold_go;
        run_random_sets(80);
    endtask

    task automatic test_drain_between_sets();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        for (int k = 0; k < 6; k++)
        begin
            send_random_set();
            pause_until_drained();
        end
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_streaming();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_idling();
        test_output_backpressure();
        test_drain_between_sets();
        pause_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_modes.size() == 0)
            $display("** mode_and_multiplicity_finder_unit: PASSED **");
        else
            $display("** mode_and_multiplicity_finder_unit: FAILED **");
        $finish;
    end

endmodule
